[rtl/tlpl_pkg.sv]
// Shared types and constants for the trie longest-prefix lookup unit.
// No dependencies; imported by every module of the block.
package tlpl_pkg;

    localparam int IDX_W       = 20;
    localparam int CNT_W       = 21;
    localparam int NET_W       = 32;
    localparam int NETIDX_W    = 31;
    localparam int ADDR_W      = 128;
    localparam int BYTES_W     = 5;
    localparam int BITS_W      = 8;
    localparam int NODE_DEPTH  = 1 << IDX_W;
    localparam int MAX_BYTES   = ADDR_W / 8;

    localparam int S_TDATA_W   = 248;
    localparam int M_TDATA_W   = 40;

    localparam logic [0:0] CMD_WRITE  = 1'b0;
    localparam logic [0:0] CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [NET_W-1:0] net;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
    } node_t;

    typedef struct packed {
        logic load;
        logic rd_start;
        logic step;
        logic apply;
        logic set_oor;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic start_ok;
        logic child_ok;
        logic walk_end;
    } dp_status_t;

endpackage

[rtl/trie_longest_prefix_lookup_unit.sv]
// Top level of the trie longest-prefix lookup unit.
// Depends on tlpl_pkg, tlpl_node_mem, tlpl_ctrl and tlpl_datapath.
//
// Items arrive on the s_ channel; s_tuser selects a node write (0) or a lookup (1).
// A write item stores one trie node in the cycle it is accepted and gives no result.
// A lookup item walks its address bits MSB first and gives one result item on m_.
// A lookup walks at most 128 address bits; an empty lookup or one with an out of range
// start node gives its result without reading the node store.
// Each address bit costs one read of the single node memory read port, whose data
// selects the next node to read. The input is not ready while a lookup is in work and
// is ready again in the cycle that the result appears. The result waits in an output
// register; the next item may be accepted while it waits, and a stalled m_tready only
// holds the walk in its final state.
// cfg_we writes the node count used for the bound check of every visited node.
// Reset clears the state machine, the output valid flag and the node count.
// The node store is not cleared and must be written before it is read.
module trie_longest_prefix_lookup_unit
    import tlpl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // node_index, left_child, right_child, net_word, addr_hi, addr_lo,
    // addr_bytes, start_node, zero pad.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command.
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found, net_index, out_of_range, zero pad.
    output logic [M_TDATA_W-1:0] m_tdata
);

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic                wr_en;
    node_t               wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    node_t               rd_data;
    logic                out_found;
    logic [NETIDX_W-1:0] out_net_index;
    logic                out_oor;

    assign wr_en         = s_tvalid && s_tready && (s_tuser == CMD_WRITE);
    assign wr_data.left  = s_tdata[39:20];
    assign wr_data.right = s_tdata[59:40];
    assign wr_data.net   = s_tdata[91:60];

    tlpl_node_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s_tdata[19:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tlpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_lookup (s_tuser == CMD_LOOKUP),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tlpl_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .addr_hi       (s_tdata[155:92]),
        .addr_lo       (s_tdata[219:156]),
        .addr_bytes    (s_tdata[224:220]),
        .start_node    (s_tdata[244:225]),
        .cmd           (cmd),
        .status        (status),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_found     (out_found),
        .out_net_index (out_net_index),
        .out_oor       (out_oor)
    );

    assign m_tdata = {7'b0, out_oor, out_net_index, out_found};

endmodule

[rtl/tlpl_node_mem.sv]
// Node store of the trie: one word per node with both children and the network word.
// Depends on tlpl_pkg. One write port and one registered read port.
module tlpl_node_mem
    import tlpl_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  node_t            wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output node_t            rd_data
);

    node_t mem [NODE_DEPTH];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tlpl_ctrl.sv]
// Controller state machine of the lookup walk and the output valid flag.
// Depends on tlpl_pkg; drives the datapath through dp_cmd_t.
module tlpl_ctrl
    import tlpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_lookup,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_PICK   = 5'b00100,
        ST_APPLY  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_lookup)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.empty)
                begin
                    state_next = ST_FINISH;
                end
                else if (!status.start_ok)
                begin
                    cmd.set_oor = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (!status.child_ok)
                begin
                    cmd.set_oor = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                if (status.walk_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (!status.child_ok)
                begin
                    cmd.set_oor = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/tlpl_datapath.sv]
// Datapath of the lookup walk: node pointer, address shifter, bit count and match result.
// Depends on tlpl_pkg; reads the node store through its registered read port.
module tlpl_datapath
    import tlpl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_wdata,
    input  logic [ADDR_W/2-1:0] addr_hi,
    input  logic [ADDR_W/2-1:0] addr_lo,
    input  logic [BYTES_W-1:0]  addr_bytes,
    input  logic [IDX_W-1:0]    start_node,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  node_t               rd_data,
    output logic                out_found,
    output logic [NETIDX_W-1:0] out_net_index,
    output logic                out_oor
);

    logic [CNT_W-1:0]    node_count_reg;
    logic [IDX_W-1:0]    start_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [BITS_W-1:0]   rem_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                found_reg;
    logic [NETIDX_W-1:0] net_reg;
    logic                oor_reg;
    logic                out_found_reg;
    logic [NETIDX_W-1:0] out_net_reg;
    logic                out_oor_reg;
    logic [IDX_W-1:0]    child;
    logic [BITS_W-1:0]   nbits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    assign nbits = (addr_bytes > BYTES_W'(MAX_BYTES)) ? BITS_W'(ADDR_W)
                                                      : {addr_bytes, 3'b000};
    assign child = addr_reg[ADDR_W-1] ? rd_data.right : rd_data.left;

    assign status.empty    = (rem_reg == '0);
    assign status.start_ok = ({1'b0, start_reg} < node_count_reg);
    assign status.child_ok = ({1'b0, child} < node_count_reg);
    assign status.walk_end = (cur_reg == '0) || (rem_reg == '0);

    assign rd_en   = cmd.rd_start || cmd.step;
    assign rd_addr = cmd.rd_start ? start_reg : child;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= start_node;
            addr_reg  <= {addr_hi, addr_lo};
            rem_reg   <= nbits;
            found_reg <= 1'b0;
            net_reg   <= '0;
            oor_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                cur_reg  <= child;
                rem_reg  <= rem_reg - BITS_W'(1);
                addr_reg <= {addr_reg[ADDR_W-2:0], 1'b0};
            end
            if (cmd.set_oor)
            begin
                found_reg <= 1'b0;
                net_reg   <= '0;
                oor_reg   <= 1'b1;
            end
            else if (cmd.apply && !rd_data.net[NET_W-1])
            begin
                found_reg <= 1'b1;
                net_reg   <= rd_data.net[NETIDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg <= found_reg;
            out_net_reg   <= net_reg;
            out_oor_reg   <= oor_reg;
        end
    end

    assign out_found     = out_found_reg;
    assign out_net_index = out_net_reg;
    assign out_oor       = out_oor_reg;

endmodule

[rtl/tlpl_checker.sv]
// Port-level checks of the trie longest-prefix lookup unit, bound to the top level.
// Depends on tlpl_pkg and trie_longest_prefix_lookup_unit.
module tlpl_checker
    import tlpl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_net_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[31:1] == '0)
        else $error("network index set without a match");

    a_oor_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> !m_tdata[0])
        else $error("match reported on an out of range walk");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tuser == CMD_LOOKUP |=> !s_tready)
        else $error("input ready during a lookup");

    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tuser == CMD_WRITE |=> s_tready)
        else $error("node write left the input not ready");

endmodule

bind trie_longest_prefix_lookup_unit tlpl_checker u_tlpl_checker (.*);

[bench/trie_match_checker.sv]
`timescale 1ns / 100ps
// Checker for the trie longest-prefix lookup unit: watches the config port and both
// stream channels, keeps its own copy of the node store and predicts every lookup.
// Depends on tlpl_pkg for widths and command codes.
module trie_match_checker
    import tlpl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic                found;
        logic [NETIDX_W-1:0] net;
        logic                oor;
    } match_t;

    logic [2*IDX_W-1:0] child_store [bit [IDX_W-1:0]];
    logic [NET_W-1:0]   net_store [bit [IDX_W-1:0]];
    logic [CNT_W-1:0]   node_limit;
    match_t             expected_matches [$];
    match_t             want;

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t: mismatch in %s: got %0h, wanted %0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    function automatic match_t walk_trie(input logic [ADDR_W-1:0] addr,
                                         input logic [BYTES_W-1:0] nbytes,
                                         input logic [IDX_W-1:0] start);
        match_t             res;
        logic [IDX_W-1:0]   cur;
        logic [2*IDX_W-1:0] kids;
        logic [NET_W-1:0]   word;
        int                 nbits;
        res = '0;
        cur = start;
        nbits = int'(nbytes) * 8;
        if (nbits > ADDR_W)
            nbits = ADDR_W;
        for (int k = 0; k < nbits; k++)
        begin
            if ({1'b0, cur} >= node_limit)
            begin
                res.oor = 1'b1;
                break;
            end
            kids = child_store.exists(cur) ? child_store[cur] : '0;
            cur = addr[ADDR_W-1-k] ? kids[2*IDX_W-1:IDX_W] : kids[IDX_W-1:0];
            if ({1'b0, cur} >= node_limit)
            begin
                res.oor = 1'b1;
                break;
            end
            word = net_store.exists(cur) ? net_store[cur] : '0;
            if (!word[NET_W-1])
            begin
                res.found = 1'b1;
                res.net = word[NETIDX_W-1:0];
            end
            if (cur == '0)
                break;
        end
        if (res.oor)
        begin
            res.found = 1'b0;
            res.net = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit <= '0;
            expected_matches.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                node_limit <= cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch("result with none expected", m_tdata[31:0], '0);
                else
                begin
                    want = expected_matches.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch("found", 32'(m_tdata[0]), 32'(want.found));
                    if (m_tdata[31:1] !== want.net)
                        report_mismatch("net_index", 32'(m_tdata[31:1]), 32'(want.net));
                    if (m_tdata[32] !== want.oor)
                        report_mismatch("out_of_range", 32'(m_tdata[32]), 32'(want.oor));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                begin
                    child_store[s_tdata[19:0]] = {s_tdata[59:40], s_tdata[39:20]};
                    net_store[s_tdata[19:0]] = s_tdata[91:60];
                end
                else
                    expected_matches.push_back(walk_trie({s_tdata[155:92], s_tdata[219:156]},
                                                         s_tdata[224:220], s_tdata[244:225]));
            end
            outstanding <= expected_matches.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the trie longest-prefix lookup unit: clock, reset, node and lookup
// stimulus, result back-pressure and the verdict. Depends on tlpl_pkg and trie_match_checker.
module tb;
    import tlpl_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   outstanding;

    logic [IDX_W-1:0]     node_pool [64];
    int unsigned          cur_limit;
    bit                   sender_calm;

    trie_longest_prefix_lookup_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    trie_match_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_item(input logic [0:0] kind, input logic [S_TDATA_W-1:0] payload);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] left,
                              input logic [IDX_W-1:0] right, input logic [NET_W-1:0] net);
        send_item(CMD_WRITE, {3'b000, IDX_W'($urandom), BYTES_W'($urandom),
                              {$urandom, $urandom}, {$urandom, $urandom},
                              net, right, left, idx});
    endtask

    task automatic lookup(input logic [63:0] hi, input logic [63:0] lo,
                          input logic [BYTES_W-1:0] nbytes, input logic [IDX_W-1:0] start);
        send_item(CMD_LOOKUP, {3'b000, start, nbytes, lo, hi, $urandom,
                               IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom)});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_node_count(input int unsigned value);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = value;
    endtask

    // Children and start nodes point either into the written pool or beyond the node
    // count, so that no walk ever reads a node that was never written.
    function automatic logic [IDX_W-1:0] pick_child();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25 && cur_limit < NODE_DEPTH)
            return IDX_W'($urandom_range(cur_limit, NODE_DEPTH - 1));
        return node_pool[$urandom_range(0, 63)];
    endfunction

    function automatic logic [IDX_W-1:0] pick_start();
        if ($urandom_range(0, 9) == 0 && cur_limit < NODE_DEPTH)
            return IDX_W'($urandom_range(cur_limit, NODE_DEPTH - 1));
        return node_pool[$urandom_range(0, 63)];
    endfunction

    function automatic logic [NET_W-1:0] pick_net();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return {1'b1, 31'($urandom)};
        if (r < 45)
            return 32'hFFFF_FFFF;
        if (r < 50)
            return '0;
        return {1'b0, 31'($urandom)};
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return BYTES_W'(MAX_BYTES);
        if (r < 35)
            return BYTES_W'(4);
        return BYTES_W'($urandom_range(0, MAX_BYTES));
    endfunction

    task automatic random_phase(input int unsigned limit, input int count);
        int r;
        set_node_count(limit);
        sender_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 64; i++)
            write_node(node_pool[i], pick_child(), pick_child(), pick_net());
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                lookup({$urandom, $urandom}, {$urandom, $urandom}, pick_bytes(), pick_start());
            else if (r < 92)
                write_node(node_pool[$urandom_range(0, 63)], pick_child(), pick_child(),
                           pick_net());
            else
                write_node(IDX_W'($urandom), pick_child(), pick_child(), pick_net());
        end
    endtask

    initial
    begin
        int taken;
        int gap;
        bit calm;
        taken = 0;
        calm = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 14);
            if (taken == 120)
                gap = 400;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        #30000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cur_limit = 0;
        sender_calm = 1'b0;
        for (int i = 0; i < 64; i++)
            node_pool[i] = (i < 32) ? IDX_W'(i) : IDX_W'(NODE_DEPTH - 64 + i);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A small hand-built trie: node 1 and node 3 point at each other, so an
        // alternating address walks all 128 bits; node 2 leads out of range.
        set_node_count(4);
        write_node(0, 1, 2, 32'h8000_0000);
        write_node(1, 0, 3, 32'h0000_0000);
        write_node(2, 3, 20'hFFFFF, 32'h7FFF_FFFF);
        write_node(3, 1, 2, 32'hFFFF_FFFF);
        lookup('0, '0, 0, 0);
        lookup('0, '0, 16, 0);
        lookup('1, '1, 16, 0);
        lookup('0, '0, 1, 4);
        lookup('1, '1, 4, 20'hFFFFF);
        lookup(64'h4000_0000_0000_0000, '0, 4, 0);
        lookup(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 16, 0);
        lookup(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 16, 3);
        lookup('0, '0, 16, 3);
        set_node_count(0);
        lookup('1, '1, 4, 0);
        lookup('0, '0, 0, 0);

        random_phase(32, 180);
        random_phase(NODE_DEPTH, 180);
        random_phase(0, 120);
        random_phase(17, 180);
        random_phase(NODE_DEPTH - 1, 180);
        random_phase(1, 150);
        random_phase($urandom_range(2, NODE_DEPTH), 180);
        random_phase(64, 180);
        random_phase(NODE_DEPTH, 180);

        wait_drained();
        repeat (140) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
